### rtl/pip_pkg.sv
package pip_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int EDGE_LANES  = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic        [1:0]             count_t;
    typedef logic        [1:0]             loc_t;

    localparam loc_t LOC_OUTSIDE  = 2'd0;
    localparam loc_t LOC_INSIDE   = 2'd1;
    localparam loc_t LOC_BOUNDARY = 2'd2;

    localparam count_t COUNT_MAX = 2'd3;

    // One edge, classified against the point: direct boundary hit, direct ray
    // crossing, or crossing decided by the sign of the cross product.
    typedef struct packed {
        logic  bnd;
        logic  tog;
        logic  need_sign;
        logic  up;
        diff_t dax;
        diff_t dby;
        diff_t dbx;
        diff_t day;
    } edge_t;

    typedef struct packed {
        logic                       last;
        logic                       too_few;
        edge_t [EDGE_LANES-1:0]     edges;
    } item_t;

endpackage

### rtl/pip_front.sv
module pip_front
    import pip_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_point_x,
    input  coord_t s_point_y,
    input  coord_t s_vertex_x,
    input  coord_t s_vertex_y,
    input  logic   s_last_vertex,
    input  logic   q_full,
    output logic   q_push,
    output item_t  q_item
);

    coord_t first_x_reg, first_x_next;
    coord_t first_y_reg, first_y_next;
    coord_t prev_x_reg,  prev_x_next;
    coord_t prev_y_reg,  prev_y_next;
    count_t count_reg,   count_next;
    logic   count_sat;

    function automatic edge_t classify(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                       coord_t px, coord_t py);
        edge_t e;
        logic  straddle;
        logic  a_right;
        logic  b_right;
        e.dax      = diff_t'(ax) - diff_t'(px);
        e.dby      = diff_t'(by) - diff_t'(py);
        e.dbx      = diff_t'(bx) - diff_t'(px);
        e.day      = diff_t'(ay) - diff_t'(py);
        a_right    = (ax >= px);
        b_right    = (bx > px);
        straddle   = (ay < py) != (by < py);
        e.bnd      = (by == py) && ((bx == px) || ((ay == py) && (b_right == (ax < px))));
        e.tog      = straddle && a_right && b_right;
        e.need_sign = straddle && ((a_right && !b_right) || (!a_right && b_right));
        e.up       = (by > ay);
        return e;
    endfunction

    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;
    assign count_sat = (count_reg == COUNT_MAX);

    always_comb begin
        q_item          = '0;
        q_item.last     = s_last_vertex;
        // fewer than three vertices once this one is counted
        q_item.too_few  = !count_reg[1];
        if (count_reg != 2'd0) begin
            q_item.edges[0] = classify(prev_x_reg, prev_y_reg, s_vertex_x, s_vertex_y,
                                       s_point_x, s_point_y);
        end
        if (s_last_vertex && count_reg[1]) begin
            q_item.edges[1] = classify(s_vertex_x, s_vertex_y, first_x_reg, first_y_reg,
                                       s_point_x, s_point_y);
        end
    end

    always_comb begin
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        count_next   = count_reg;
        if (q_push) begin
            if (count_reg == 2'd0) begin
                first_x_next = s_vertex_x;
                first_y_next = s_vertex_y;
            end
            prev_x_next = s_vertex_x;
            prev_y_next = s_vertex_y;
            if (s_last_vertex) begin
                count_next = 2'd0;
            end else if (!count_sat) begin
                count_next = count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

### rtl/pip_queue.sv
module pip_queue
    import pip_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  head_valid,
    input  logic  pop,
    output item_t head_item
);

    item_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_WIDTH-1:0] cnt_reg,    cnt_next;
    logic                  do_pop;

    assign full       = (cnt_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### rtl/pip_back.sv
module pip_back
    import pip_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  m_valid,
    input  logic  m_ready,
    output loc_t  m_location
);

    // product stage
    logic                   mul_valid_reg, mul_valid_next;
    logic                   mul_last_reg;
    logic                   mul_too_few_reg;
    logic [EDGE_LANES-1:0]  mul_bnd_reg;
    logic [EDGE_LANES-1:0]  mul_tog_reg;
    logic [EDGE_LANES-1:0]  mul_sign_reg;
    logic [EDGE_LANES-1:0]  mul_up_reg;
    prod_t                  mul_p1_reg [EDGE_LANES];
    prod_t                  mul_p2_reg [EDGE_LANES];

    // accumulators and result register
    logic                   parity_reg,   parity_next;
    logic                   boundary_reg, boundary_next;
    logic                   out_valid_reg, out_valid_next;
    loc_t                   out_loc_reg,   out_loc_next;

    logic                   mul_take;
    logic                   load;
    logic [EDGE_LANES-1:0]  lane_hit;
    logic [EDGE_LANES-1:0]  lane_tog;
    logic                   par_acc;
    logic                   bnd_acc;

    assign mul_take = mul_valid_reg && (!mul_last_reg || !out_valid_reg || m_ready);
    assign in_ready = !mul_valid_reg || mul_take;
    assign load     = in_valid && in_ready;

    assign m_valid    = out_valid_reg;
    assign m_location = out_loc_reg;

    always_comb begin
        for (int i = 0; i < EDGE_LANES; i++) begin
            lane_hit[i] = mul_bnd_reg[i] || (mul_sign_reg[i] && (mul_p1_reg[i] == mul_p2_reg[i]));
            lane_tog[i] = mul_tog_reg[i] ||
                          (mul_sign_reg[i] && (mul_p1_reg[i] != mul_p2_reg[i]) &&
                           ((mul_p1_reg[i] > mul_p2_reg[i]) == mul_up_reg[i]));
        end
        par_acc = parity_reg ^ (^lane_tog);
        bnd_acc = boundary_reg | (|lane_hit);
    end

    always_comb begin
        mul_valid_next = load ? 1'b1 : (mul_take ? 1'b0 : mul_valid_reg);
        parity_next    = parity_reg;
        boundary_next  = boundary_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_loc_next   = out_loc_reg;
        if (mul_take) begin
            if (mul_last_reg) begin
                parity_next    = 1'b0;
                boundary_next  = 1'b0;
                out_valid_next = 1'b1;
                if (mul_too_few_reg) begin
                    out_loc_next = LOC_OUTSIDE;
                end else if (bnd_acc) begin
                    out_loc_next = LOC_BOUNDARY;
                end else if (par_acc) begin
                    out_loc_next = LOC_INSIDE;
                end else begin
                    out_loc_next = LOC_OUTSIDE;
                end
            end else begin
                parity_next   = par_acc;
                boundary_next = bnd_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mul_last_reg    <= in_item.last;
            mul_too_few_reg <= in_item.too_few;
            for (int i = 0; i < EDGE_LANES; i++) begin
                mul_bnd_reg[i]  <= in_item.edges[i].bnd;
                mul_tog_reg[i]  <= in_item.edges[i].tog;
                mul_sign_reg[i] <= in_item.edges[i].need_sign;
                mul_up_reg[i]   <= in_item.edges[i].up;
                mul_p1_reg[i]   <= in_item.edges[i].dax * in_item.edges[i].dby;
                mul_p2_reg[i]   <= in_item.edges[i].dbx * in_item.edges[i].day;
            end
        end
        out_loc_reg <= out_loc_next;
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            parity_reg    <= 1'b0;
            boundary_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            parity_reg    <= parity_next;
            boundary_reg  <= boundary_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/point_in_polygon_test_core.sv
// Point-in-polygon test, streamed one vertex per request: each request carries the
// test point and one polygon vertex, the final vertex flagged by s_last_vertex, and
// the final request yields one result (0 outside, 1 inside, 2 on the boundary;
// fewer than three vertices report outside). One request is taken every clock
// cycle when the result side keeps up. The result appears on m_valid once the final
// vertex has passed the queue, the product stage and the result register: the front
// classifies the edge from the previous vertex (and, on the final vertex, the
// closing edge as well), a four-entry queue holds classified vertices,
// and the back forms the exact cross products in one registered stage of four 33 x 33
// multipliers before the sign test and parity update. A result held on m_valid stalls
// the back only; the front keeps taking vertices until the queue is full.
module point_in_polygon_test_core
    import pip_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_point_x,
    input  coord_t s_point_y,
    input  coord_t s_vertex_x,
    input  coord_t s_vertex_y,
    input  logic   s_last_vertex,
    output logic   m_valid,
    input  logic   m_ready,
    output loc_t   m_location
);

    logic  q_full;
    logic  q_push;
    item_t q_item;
    logic  head_valid;
    item_t head_item;
    logic  back_ready;

    pip_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_vertex_x    (s_vertex_x),
        .s_vertex_y    (s_vertex_y),
        .s_last_vertex (s_last_vertex),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_item)
    );

    pip_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .head_valid (head_valid),
        .pop        (back_ready),
        .head_item  (head_item)
    );

    pip_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (head_valid),
        .in_ready   (back_ready),
        .in_item    (head_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_location (m_location)
    );

endmodule

### rtl/pip_checker.sv
module pip_checker
    import pip_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    input  logic   s_ready,
    input  logic   s_last_vertex,
    input  logic   m_valid,
    input  logic   m_ready,
    input  loc_t   m_location
);

    // polygons closed on the request side but not yet delivered
    logic [3:0] pending_reg, pending_next;
    logic       close_in;
    logic       result_out;

    assign close_in   = s_valid && s_ready && s_last_vertex;
    assign result_out = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (close_in && !result_out) begin
            pending_next = pending_reg + 4'd1;
        end else if (!close_in && result_out) begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 4'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_no_spurious_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != 4'd0))
        else $error("result without a closed polygon");

    a_location_code: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_location == LOC_OUTSIDE || m_location == LOC_INSIDE ||
                     m_location == LOC_BOUNDARY))
        else $error("undefined location code");

    a_stall_only_on_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled while no result waits");

    a_result_held: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_location)))
        else $error("stalled result dropped or changed");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (.*);
